### src/matrix_vector_multiply_top_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MVM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define MVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, from item accept to result strobe.
`define MVM_ASSERT_LAT4(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
        else $error(msg);

`endif

### src/mvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

    // Fixed lane count: one item carries four elements
    localparam int LANES    = 4;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int ACC_W    = 48;
    localparam int CHUNK_W  = 6;
    localparam int SIZE_W   = 9;
    localparam int ROW_W    = 8;
    // Chunk count is held one bit wider than chunk_index so it can reach 64
    localparam int CNT_W    = CHUNK_W + 1;
    localparam int MAX_CHUNKS = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } t_opcode;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_opcode                    opcode;
        logic [CHUNK_W-1:0]         chunk_index;
        logic signed [ELEM_W-1:0]   elem_a;
        logic signed [ELEM_W-1:0]   elem_b;
        logic signed [ELEM_W-1:0]   elem_c;
        logic signed [ELEM_W-1:0]   elem_d;
        logic signed [ACC_W-1:0]    start_value;
    } t_item;

    typedef struct packed {
        logic signed [ACC_W-1:0]    row_result;
        logic [ROW_W-1:0]           row_number;
    } t_result;

    // Row control travelling alongside the lane products
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       last;
        logic signed [ACC_W-1:0]    start_value;
    } t_ctrl;

endpackage

`default_nettype wire

### src/matrix_vector_multiply_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_vector_multiply_top_macros.svh"

// Streaming c = A*b. Load b with opcode LOAD items (four elements each), then
// send matrix rows as ROW items, four columns a chunk. One item is taken every
// clock: busy is always low. A row chunk's four products are formed in four
// parallel lanes, each owning a bank of min(64, MAX_SIZE/4) vector words, and
// summed and accumulated by the merge stage. The result of the last chunk of a
// row appears on o_result with o_strobe high for one cycle, via r_ctrl1,
// r_ctrl2 and the merge registers. The receiver cannot stall results; it must
// take each strobed item. The vector store is not reset and needs no clearing
// pass: load it before sending rows. Change the size register only when idle.
module matrix_vector_multiply_top
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_item             i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    output logic                   o_strobe,
    output t_result                o_result
);

    localparam int DEPTH = (MAX_SIZE / LANES > MAX_CHUNKS) ? MAX_CHUNKS : MAX_SIZE / LANES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  chunks;
    logic [SIZE_W-1:0] rows;
    logic              wr_en;
    t_ctrl             n_ctrl;
    t_ctrl             r_ctrl1;
    t_ctrl             r_ctrl2;
    t_elem             lane_elem [LANES];
    t_prod             lane_prod [LANES];

    assign busy = 1'b0;

    // Size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    // Chunks per row: size/4, capped at the bank depth, at least one
    always_comb begin
        chunks = r_size[SIZE_W-1:2];
        if (chunks > CNT_W'(DEPTH)) begin
            chunks = CNT_W'(DEPTH);
        end
        if (chunks == '0) begin
            chunks = CNT_W'(1);
        end
        rows = SIZE_W'({chunks, 2'b00});
    end

    // Item decode
    always_comb begin
        wr_en = start && (i_item.opcode == OP_LOAD)
                && ({1'b0, i_item.chunk_index} < CNT_W'(DEPTH));
        n_ctrl.valid       = start && (i_item.opcode == OP_ROW)
                             && ({1'b0, i_item.chunk_index} < chunks);
        n_ctrl.first       = (i_item.chunk_index == '0);
        n_ctrl.last        = ({1'b0, i_item.chunk_index} == chunks - CNT_W'(1));
        n_ctrl.start_value = i_item.start_value;
        lane_elem[0] = i_item.elem_a;
        lane_elem[1] = i_item.elem_b;
        lane_elem[2] = i_item.elem_c;
        lane_elem[3] = i_item.elem_d;
    end

    // Control delayed to line up with the lane products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
        end else begin
            r_ctrl1 <= n_ctrl;
            r_ctrl2 <= r_ctrl1;
        end
    end

    // Four lanes: vector bank and multiplier each
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mvm_lane #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_wr_en (wr_en),
            .i_addr  (i_item.chunk_index[AW-1:0]),
            .i_elem  (lane_elem[g]),
            .o_prod  (lane_prod[g])
        );
    end

    // Lane sum, accumulate and row output
    mvm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (r_ctrl2),
        .i_prod   (lane_prod),
        .i_rows   (rows),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `MVM_ASSERT_LAT4(a_load_silent, i_clk, i_rst_n, start && (i_item.opcode == OP_LOAD), !o_strobe, "vector load produced a result")
    `MVM_ASSERT_LAT4(a_row_latency, i_clk, i_rst_n, n_ctrl.valid && n_ctrl.last, o_strobe, "last row chunk gave no result")

endmodule

`default_nettype wire

### src/mvm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mvm_lane
    import mvm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_elem         i_elem,
    output t_prod              o_prod
);

    // This lane's slice of the vector: column 4*addr + lane
    logic [ELEM_W-1:0] r_bank [DEPTH];
    t_elem             r_elem;
    t_elem             r_vec;
    t_prod             r_prod;

    // Bank write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_bank[i_addr] <= i_elem;
        end
        r_vec  <= t_elem'(r_bank[i_addr]);
        r_elem <= i_elem;
    end

    // One 16x16 signed multiply per lane
    always_ff @(posedge i_clk) begin
        r_prod <= r_elem * r_vec;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### src/mvm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_vector_multiply_top_macros.svh"

module mvm_merge
    import mvm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl             i_ctrl,
    input  wire t_prod             i_prod [LANES],
    input  wire logic [SIZE_W-1:0] i_rows,
    output logic                   o_strobe,
    output t_result                o_result
);

    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;
    t_ctrl                   r_ctrl;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;
    logic [ROW_W-1:0]        n_row;
    logic [ROW_W-1:0]        r_row;
    logic                    r_strobe;
    t_result                 r_result;

    // Add the four lane products
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            n_sum = n_sum + SUM_W'(i_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_sum <= n_sum;
    end

    // Row accumulator, reloaded by the first chunk of a row
    always_comb begin
        n_acc = (r_ctrl.first ? r_ctrl.start_value : r_acc) + ACC_W'(r_sum);
    end

    // Row counter wraps after the last row of the matrix
    always_comb begin
        if ({1'b0, r_row} + SIZE_W'(1) >= i_rows) begin
            n_row = '0;
        end else begin
            n_row = r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_row    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ctrl.valid && r_ctrl.last;
            if (r_ctrl.valid) begin
                r_acc <= n_acc;
                if (r_ctrl.last) begin
                    r_row <= n_row;
                end
            end
        end
        r_result.row_result <= n_acc;
        r_result.row_number <= r_row;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `MVM_ASSERT_NOW(a_strobe_src, i_clk, i_rst_n, r_strobe, $past(r_ctrl.valid && r_ctrl.last), "result strobe without a finished row")
    `MVM_ASSERT_NOW(a_row_step, i_clk, i_rst_n, r_strobe, (r_row == '0) || (r_row == r_result.row_number + ROW_W'(1)), "row counter did not step past emitted row")
    `MVM_ASSERT_NEXT(a_acc_hold, i_clk, i_rst_n, !r_ctrl.valid, $stable(r_acc), "accumulator moved without a row chunk")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mvm_pkg::*;

    localparam int VEC_DEPTH      = 256;
    localparam int VEC_CHUNKS     = VEC_DEPTH / LANES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 40;
    localparam int RAND_ITEMS     = 400;
    localparam int N_PHASES       = 14;

    localparam t_elem ELEM_MAX = 16'sh7FFF;
    localparam t_elem ELEM_MIN = 16'sh8000;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Tracks vector store, row sum and row number; holds the row sums still due
    class row_sum_tracker;
        t_elem                   vec_words [VEC_DEPTH];
        logic signed [ACC_W-1:0] row_acc;
        logic [ROW_W-1:0]        row_count;
        logic [SIZE_W-1:0]       size_reg;
        t_result                 pending_rows [$];
        int                      mismatches;

        function new();
            row_acc    = '0;
            row_count  = '0;
            size_reg   = SIZE_RESET;
            mismatches = 0;
        endfunction

        // Chunks per row: size / 4, at least one, capped by the store
        function int chunks_in_use();
            int n;
            n = int'(size_reg) >> 2;
            if (n > MAX_CHUNKS) n = MAX_CHUNKS;
            if (n > VEC_CHUNKS) n = VEC_CHUNKS;
            if (n == 0) n = 1;
            return n;
        endfunction

        function void take_item(t_item it);
            t_elem   lane [LANES];
            longint  dot;
            int      base;
            int      n;
            t_result row;
            lane[0] = it.elem_a;
            lane[1] = it.elem_b;
            lane[2] = it.elem_c;
            lane[3] = it.elem_d;
            base = int'(it.chunk_index) * LANES;
            if (it.opcode == OP_LOAD) begin
                for (int k = 0; k < LANES; k++)
                    if (base + k < VEC_DEPTH) vec_words[base + k] = lane[k];
                return;
            end
            n = chunks_in_use();
            // chunk beyond the row end: no effect at all
            if (int'(it.chunk_index) >= n) return;
            dot = 0;
            for (int k = 0; k < LANES; k++)
                dot += longint'(lane[k]) * longint'(vec_words[base + k]);
            if (it.chunk_index == 0) row_acc = it.start_value;
            row_acc = row_acc + dot[ACC_W-1:0];
            if (int'(it.chunk_index) == n - 1) begin
                row.row_result = row_acc;
                row.row_number = row_count;
                pending_rows.push_back(row);
                if (int'(row_count) + 1 >= n * LANES) row_count = '0;
                else row_count = row_count + 1'b1;
            end
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void check_row(t_result got);
            t_result want;
            if (pending_rows.size() == 0) begin
                flag($sformatf("unexpected row: result %0d row %0d",
                               got.row_result, got.row_number));
                return;
            end
            want = pending_rows.pop_front();
            if (got.row_result !== want.row_result || got.row_number !== want.row_number)
                flag($sformatf("row mismatch: result exp %0d got %0d, row exp %0d got %0d",
                               want.row_result, got.row_result,
                               want.row_number, got.row_number));
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    t_item             i_item     = '0;
    logic              i_cfg_we   = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data = SIZE_RESET;
    logic              o_strobe;
    t_result           o_result;

    row_sum_tracker chk = new();
    bit             loaded [VEC_CHUNKS];
    int             gap_pct    = 0;
    int             items_sent = 0;
    int             quiet      = 0;
    int             phase_size [N_PHASES] =
        '{4, 8, 256, 0, 16, 3, 12, 511, 32, 260, 20, 4, 64, 7};

    matrix_vector_multiply_top #(
        .MAX_SIZE   (VEC_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor: note accepted items, check strobed rows
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) chk.take_item(i_item);
        if (i_rst_n && o_strobe) chk.check_row(o_result);
    end

    // Watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_strobe || i_cfg_we) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_elem rand_elem();
        if ($urandom_range(7) == 0) return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
        return t_elem'($urandom);
    endfunction

    function automatic logic signed [ACC_W-1:0] rand_acc();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ACC_W-1:0];
    endfunction

    function automatic t_item make_item(t_opcode op, int chunk, t_elem a, t_elem b,
                                        t_elem c, t_elem d,
                                        logic signed [ACC_W-1:0] sv);
        t_item it;
        it.opcode      = op;
        it.chunk_index = chunk[CHUNK_W-1:0];
        it.elem_a      = a;
        it.elem_b      = b;
        it.elem_c      = c;
        it.elem_d      = d;
        it.start_value = sv;
        return it;
    endfunction

    // Present one item, hold until taken, then an optional random gap
    task automatic send_item(t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (it.opcode == OP_LOAD) loaded[it.chunk_index] = 1'b1;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_load(int chunk);
        send_item(make_item(OP_LOAD, chunk, rand_elem(), rand_elem(), rand_elem(),
                            rand_elem(), rand_acc()));
    endtask

    // Row chunk with random content; the store slice is loaded first if need be
    task automatic send_row(int chunk);
        if (chunk < VEC_CHUNKS && !loaded[chunk]) send_load(chunk);
        send_item(make_item(OP_ROW, chunk, rand_elem(), rand_elem(), rand_elem(),
                            rand_elem(), rand_acc()));
    endtask

    // Stop sending, wait for all rows due, then let the pipe run empty
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (chk.pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(int value);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        chk.size_reg = value[SIZE_W-1:0];
    endtask

    task automatic run_directed();
        // one chunk per row
        write_size(4);
        send_item(make_item(OP_LOAD, 0, ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MAX, '0));
        // dot of +1 on top of the largest start: wraps to the most negative sum
        send_item(make_item(OP_ROW, 0, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ACC_MAX));
        // negative dot on the most negative start: wraps the other way
        send_item(make_item(OP_ROW, 0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, ACC_MIN));
        // chunks past the row end are dropped
        send_item(make_item(OP_ROW, 1, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN, rand_acc()));
        send_item(make_item(OP_ROW, MAX_CHUNKS - 1, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                            ELEM_MIN, rand_acc()));
        send_item(make_item(OP_ROW, 0, '0, '0, '0, '0, '0));
        // fourth and fifth rows: row number wraps back to zero
        send_row(0);
        send_row(0);
        send_item(make_item(OP_LOAD, 1, rand_elem(), rand_elem(), rand_elem(),
                            rand_elem(), '0));
        send_item(make_item(OP_LOAD, MAX_CHUNKS - 1, ELEM_MAX, ELEM_MIN, -16'sd1, '0,
                            ACC_MAX));
        // two chunks; last chunk first, then reload, then last chunk twice
        write_size(8);
        send_row(1);
        send_row(0);
        send_row(1);
        send_row(1);
        send_row(2);
        // size below four still gives one chunk
        write_size(3);
        send_row(0);
        // all bits set: 64 chunks, last chunk alone emits a row
        write_size(511);
        send_row(MAX_CHUNKS - 1);
    endtask

    task automatic run_phase();
        int used;
        int n;
        int kind;
        int len;
        int i;
        int j;
        int tmp;
        int order [$];
        used = 0;
        while (used < PHASE_ITEMS) begin
            n    = chk.chunks_in_use();
            kind = $urandom_range(99);
            if (kind < 65) begin
                // whole row, sometimes with two chunks swapped
                order = {};
                for (int c = 0; c < n; c++) order.push_back(c);
                if (n > 1 && $urandom_range(4) == 0) begin
                    i = $urandom_range(n - 1);
                    j = $urandom_range(n - 1);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                foreach (order[k]) send_row(order[k]);
                used += n;
            end else if (kind < 78) begin
                send_load($urandom_range(MAX_CHUNKS - 1));
                used++;
            end else if (kind < 90) begin
                send_row($urandom_range(MAX_CHUNKS - 1));
                used++;
            end else begin
                // row cut short
                len = $urandom_range(n, 1);
                for (int c = 0; c < len; c++) send_row(c);
                used += len;
            end
        end
    endtask

    initial begin
        int p;
        p = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            write_size(phase_size[p % N_PHASES]);
            case (p % 4)
                1:       gap_pct = 84;
                3:       gap_pct = 30;
                default: gap_pct = 0;
            endcase
            run_phase();
            p++;
        end
        gap_pct = 0;
        drain_pipeline();
        if (chk.mismatches == 0 && chk.pending_rows.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
